// File: design/accelerometer_step_counter_macros.svh
// assertion macros for the accelerometer step counter
// used by the top level only; depends on nothing else

`ifndef ACCELEROMETER_STEP_COUNTER_MACROS_SVH
`define ACCELEROMETER_STEP_COUNTER_MACROS_SVH

// same-cycle implication under synchronous reset
`define ACS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under synchronous reset
`define ACS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/acs_pkg.sv
// shared types and constants for the accelerometer step counter
// no dependencies; imported by every module of the block
`default_nettype none

package acs_pkg;

  // sample and datapath widths
  localparam int SAMPLE_BITS = 10;
  localparam int MAG_BITS    = SAMPLE_BITS + 1;
  localparam int SUM_BITS    = 2 * SAMPLE_BITS + 2;
  localparam int ROOT_STEPS  = SUM_BITS / 2;
  localparam int CNT_BITS    = $clog2(ROOT_STEPS);
  localparam int REM_BITS    = MAG_BITS + 1;
  localparam int SQ_BITS     = 2 * SAMPLE_BITS;

  // configuration register widths
  localparam int WEIGHT_BITS = 10;
  localparam int MARGIN_BITS = 11;
  localparam int TARGET_BITS = 8;
  localparam int ADDR_BITS   = 4;
  localparam int DATA_BITS   = 32;
  localparam int PROD_BITS   = WEIGHT_BITS + MAG_BITS;

  // register indexes
  localparam logic [1:0] REG_WEIGHT = 2'd0;
  localparam logic [1:0] REG_MARGIN = 2'd1;
  localparam logic [1:0] REG_TARGET = 2'd2;

  // register reset values
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 10'd128;
  localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 11'd25;
  localparam logic [TARGET_BITS-1:0] TARGET_RESET = 8'd5;

  // arithmetic constants
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_FULL  = 10'd1023;
  localparam logic [MAG_BITS-1:0]    VALLEY_START = 11'd1024;
  localparam logic [TARGET_BITS-1:0] SETTLE_MAX   = 8'd255;

  // magnitude queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] acc_x;
    logic [SAMPLE_BITS-1:0] acc_y;
    logic [SAMPLE_BITS-1:0] acc_z;
  } in_item_t;

  typedef struct packed {
    logic [10:0] magnitude;
    logic [10:0] average;
    logic [31:0] step_total;
    logic [1:0]  phase;
    logic        step_seen;
  } out_item_t;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] weight;
    logic [MARGIN_BITS-1:0] margin;
    logic [TARGET_BITS-1:0] settle_target;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    PH_SEEK_MAX   = 2'd0,
    PH_CROSS_DOWN = 2'd1,
    PH_SEEK_MIN   = 2'd2,
    PH_CROSS_UP   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_SQUARE,
    FR_ROOT,
    FR_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_AVG,
    BK_DET
  } back_state_t;

endpackage

`default_nettype wire

// File: design/acs_front.sv
// front end: accepts samples, sums the squares and takes the floor square root
// depends on acs_pkg; feeds magnitudes to acs_queue
`default_nettype none

module acs_front
  import acs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire in_item_t            in_item,
  output logic                     push,
  output logic [MAG_BITS-1:0]      push_data,
  input  wire q_stat_t             q_stat
);

  front_state_t          state, state_next;
  logic [SAMPLE_BITS-1:0] ax, ay, az, ax_next, ay_next, az_next;
  logic [1:0]            sel, sel_next;
  logic [SUM_BITS-1:0]   sum, sum_next;
  logic [REM_BITS-1:0]   rem, rem_next;
  logic [MAG_BITS-1:0]   root, root_next;
  logic [CNT_BITS-1:0]   cnt, cnt_next;

  logic [SAMPLE_BITS-1:0] sq_op;
  logic [SQ_BITS-1:0]     sq;
  logic [REM_BITS+1:0]    rem_sh, trial_sub, trial_diff;
  logic                   trial_ok;

  // one square per cycle
  always_comb begin
    case (sel)
      2'd0:    sq_op = ax;
      2'd1:    sq_op = ay;
      default: sq_op = az;
    endcase
  end
  assign sq = SQ_BITS'(sq_op) * SQ_BITS'(sq_op);

  // one root bit per cycle, restoring form
  assign rem_sh     = {rem, sum[SUM_BITS-1 -: 2]};
  assign trial_sub  = {1'b0, root, 2'b01};
  assign trial_ok   = (rem_sh >= trial_sub);
  assign trial_diff = rem_sh - trial_sub;

  assign in_stall  = (state != FR_IDLE);
  assign push_data = root;

  // sequencer
  always_comb begin
    state_next = state;
    ax_next    = ax;
    ay_next    = ay;
    az_next    = az;
    sel_next   = sel;
    sum_next   = sum;
    rem_next   = rem;
    root_next  = root;
    cnt_next   = cnt;
    push       = 1'b0;
    case (state)
      FR_IDLE: begin
        if (in_valid) begin
          ax_next    = in_item.acc_x;
          ay_next    = in_item.acc_y;
          az_next    = in_item.acc_z;
          sel_next   = 2'd0;
          sum_next   = '0;
          state_next = FR_SQUARE;
        end
      end
      FR_SQUARE: begin
        sum_next = sum + SUM_BITS'(sq);
        sel_next = sel + 2'd1;
        if (sel == 2'd2) begin
          rem_next   = '0;
          root_next  = '0;
          cnt_next   = '0;
          state_next = FR_ROOT;
        end
      end
      FR_ROOT: begin
        if (trial_ok) begin
          rem_next  = trial_diff[REM_BITS-1:0];
          root_next = {root[MAG_BITS-2:0], 1'b1};
        end else begin
          rem_next  = rem_sh[REM_BITS-1:0];
          root_next = {root[MAG_BITS-2:0], 1'b0};
        end
        sum_next = {sum[SUM_BITS-3:0], 2'b00};
        cnt_next = cnt + CNT_BITS'(1);
        if (cnt == CNT_BITS'(ROOT_STEPS - 1)) begin
          state_next = FR_PUSH;
        end
      end
      FR_PUSH: begin
        if (!q_stat.full) begin
          push       = 1'b1;
          state_next = FR_IDLE;
        end
      end
      default: state_next = FR_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ax   <= ax_next;
    ay   <= ay_next;
    az   <= az_next;
    sel  <= sel_next;
    sum  <= sum_next;
    rem  <= rem_next;
    root <= root_next;
    cnt  <= cnt_next;
  end

endmodule

`default_nettype wire

// File: design/acs_queue.sv
// two-entry magnitude queue between the front and back ends
// depends on acs_pkg
`default_nettype none

module acs_queue
  import acs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire logic [MAG_BITS-1:0] push_data,
  input  wire logic                pop,
  output logic [MAG_BITS-1:0]      pop_data,
  output q_stat_t                  q_stat
);

  logic [MAG_BITS-1:0]  slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign pop_data     = slots[rd_ptr];
  assign q_stat.full  = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_BITS'(1);
        2'b01:   count <= count - QCNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: design/acs_back.sv
// back end: running average, peak/valley step detector and result register
// depends on acs_pkg; takes magnitudes from acs_queue
`default_nettype none

module acs_back
  import acs_pkg::*;
#(
  parameter int STEP_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cfg_t                cfg,
  input  wire q_stat_t             q_stat,
  output logic                     pop,
  input  wire logic [MAG_BITS-1:0] pop_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output out_item_t                out_item
);

  back_state_t          state, state_next;
  logic [MAG_BITS-1:0]  mag, mag_next;
  logic [PROD_BITS-1:0] prod, prod_next;
  logic [MAG_BITS-1:0]  avg, avg_next;
  logic [MAG_BITS-1:0]  peak, peak_next;
  logic [MAG_BITS-1:0]  valley, valley_next;
  logic [TARGET_BITS-1:0] settle, settle_next;
  phase_t               phase, phase_next;
  logic [STEP_BITS-1:0] steps, steps_next;
  logic                 seeded, seeded_next;
  logic                 out_valid_next;
  out_item_t            out_item_next;

  logic [WEIGHT_BITS-1:0] w_old;
  logic [PROD_BITS-1:0]   prod_old, avg_sum;
  logic [TARGET_BITS-1:0] settle_inc;
  logic                   settle_done;
  logic [MAG_BITS:0]      low_edge, high_edge;
  logic                   cross_down, cross_up, seen;

  // weighted average terms
  assign w_old    = WEIGHT_FULL - cfg.weight;
  assign prod_old = PROD_BITS'(w_old) * PROD_BITS'(avg);
  assign avg_sum  = prod + prod_old;

  // settle counter, saturating
  assign settle_inc  = (settle == SETTLE_MAX) ? settle : settle + TARGET_BITS'(1);
  assign settle_done = (settle_inc >= cfg.settle_target);

  // crossing thresholds; an average under the margin counts as crossed
  assign low_edge   = {1'b0, avg} - {1'b0, cfg.margin};
  assign high_edge  = {1'b0, avg} + {1'b0, cfg.margin};
  assign cross_down = low_edge[MAG_BITS] || ({1'b0, mag} < low_edge);
  assign cross_up   = ({1'b0, mag} > high_edge);

  // sequencer and detector
  always_comb begin
    state_next     = state;
    mag_next       = mag;
    prod_next      = prod;
    avg_next       = avg;
    peak_next      = peak;
    valley_next    = valley;
    settle_next    = settle;
    phase_next     = phase;
    steps_next     = steps;
    seeded_next    = seeded;
    out_valid_next = out_valid && out_stall;
    out_item_next  = out_item;
    pop            = 1'b0;
    seen           = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_stat.empty && (!out_valid || !out_stall)) begin
          pop        = 1'b1;
          mag_next   = pop_data;
          state_next = BK_MUL;
        end
      end
      BK_MUL: begin
        prod_next  = PROD_BITS'(cfg.weight) * PROD_BITS'(mag);
        state_next = BK_AVG;
      end
      BK_AVG: begin
        avg_next   = seeded ? avg_sum[PROD_BITS-1:WEIGHT_BITS] : mag;
        state_next = BK_DET;
      end
      BK_DET: begin
        if (!seeded) begin
          seeded_next = 1'b1;
        end else begin
          case (phase)
            PH_SEEK_MAX: begin
              if (mag > peak) begin
                peak_next   = mag;
                settle_next = '0;
              end else begin
                settle_next = settle_inc;
                if (settle_done) phase_next = PH_CROSS_DOWN;
              end
            end
            PH_CROSS_DOWN: begin
              if (mag > peak) begin
                peak_next   = mag;
                settle_next = '0;
                phase_next  = PH_SEEK_MAX;
              end else if (cross_down) begin
                steps_next  = steps + STEP_BITS'(1);
                valley_next = VALLEY_START;
                settle_next = '0;
                phase_next  = PH_SEEK_MIN;
                seen        = 1'b1;
              end
            end
            PH_SEEK_MIN: begin
              if (mag < valley) begin
                valley_next = mag;
                settle_next = '0;
              end else begin
                settle_next = settle_inc;
                if (settle_done) phase_next = PH_CROSS_UP;
              end
            end
            PH_CROSS_UP: begin
              if (mag < valley) begin
                valley_next = mag;
                settle_next = '0;
                phase_next  = PH_SEEK_MIN;
              end else if (cross_up) begin
                steps_next  = steps + STEP_BITS'(1);
                peak_next   = '0;
                settle_next = '0;
                phase_next  = PH_SEEK_MAX;
                seen        = 1'b1;
              end
            end
            default: phase_next = PH_SEEK_MAX;
          endcase
        end
        out_valid_next           = 1'b1;
        out_item_next.magnitude  = mag;
        out_item_next.average    = avg;
        out_item_next.step_total = 32'(steps_next);
        out_item_next.phase      = phase_next;
        out_item_next.step_seen  = seen;
        state_next               = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // control and detector state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      avg       <= '0;
      peak      <= '0;
      valley    <= VALLEY_START;
      settle    <= '0;
      phase     <= PH_SEEK_MAX;
      steps     <= '0;
      seeded    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      avg       <= avg_next;
      peak      <= peak_next;
      valley    <= valley_next;
      settle    <= settle_next;
      phase     <= phase_next;
      steps     <= steps_next;
      seeded    <= seeded_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mag      <= mag_next;
    prod     <= prod_next;
    out_item <= out_item_next;
  end

endmodule

`default_nettype wire

// File: design/accelerometer_step_counter.sv
// Accelerometer step counter, top level.
// One sample item (acc_x, acc_y, acc_z) enters on the in channel when
// in_valid is high and in_stall is low; one result item leaves on the out
// channel for every sample, in order, taken when out_valid is high and
// out_stall is low.
// Sample flow: a new sample is accepted only after the previous one has
// been loaded, squared on the front end's shared squarer, rooted by the
// bit-serial root unit (one result bit a cycle) and handed to the queue.
// The back end then passes each magnitude through pop, weight multiply,
// average and detect states before out_valid rises.
// A two-entry magnitude queue parts the front from the back, so a stalled
// receiver holds the result register while the front keeps taking samples
// until the queue fills; then in_stall stays high.
// Reset (rst, synchronous) empties the queue, drops out_valid, restores the
// detector and step count, and loads the register defaults.
// Configuration: APB writes at 0x0 (smoothing_weight), 0x4 (crossing_margin),
// 0x8 (settle_target); pready is always high. Write only while idle.
// Depends on acs_pkg, acs_front, acs_queue, acs_back and the macros header.
`default_nettype none
`include "accelerometer_step_counter_macros.svh"

module accelerometer_step_counter
  import acs_pkg::*;
#(
  parameter int STEP_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_item,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0]      prdata,
  output logic                      pready
);

  cfg_t                cfg;
  q_stat_t             q_stat;
  logic                push, pop;
  logic [MAG_BITS-1:0] push_data, pop_data;
  logic                cfg_write;
  logic [1:0]          reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.weight        <= WEIGHT_RESET;
      cfg.margin        <= MARGIN_RESET;
      cfg.settle_target <= TARGET_RESET;
    end else if (cfg_write) begin
      case (reg_index)
        REG_WEIGHT: cfg.weight        <= pwdata[WEIGHT_BITS-1:0];
        REG_MARGIN: cfg.margin        <= pwdata[MARGIN_BITS-1:0];
        REG_TARGET: cfg.settle_target <= pwdata[TARGET_BITS-1:0];
        default:    cfg               <= cfg;
      endcase
    end
  end

  // register read-back
  always_comb begin
    case (reg_index)
      REG_WEIGHT: prdata = DATA_BITS'(cfg.weight);
      REG_MARGIN: prdata = DATA_BITS'(cfg.margin);
      REG_TARGET: prdata = DATA_BITS'(cfg.settle_target);
      default:    prdata = '0;
    endcase
  end

  acs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .push      (push),
    .push_data (push_data),
    .q_stat    (q_stat)
  );

  acs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  acs_back #(
    .STEP_BITS (STEP_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_stat    (q_stat),
    .pop       (pop),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // queue is never written when full nor read when empty
  `ACS_ASSERT_NOW(a_no_push_full, clk, rst, push, !q_stat.full, "push into full queue")
  `ACS_ASSERT_NOW(a_no_pop_empty, clk, rst, pop, !q_stat.empty, "pop from empty queue")

  // a completed step always leaves the detector in a seek phase
  `ACS_ASSERT_NOW(a_step_phase, clk, rst, out_valid && out_item.step_seen, (out_item.phase == PH_SEEK_MAX || out_item.phase == PH_SEEK_MIN), "step reported outside a seek phase")

  // a pop only happens when the result register is free by the next edge
  `ACS_ASSERT_NEXT(a_pop_out_free, clk, rst, pop, !out_valid, "pop while result still pending")

endmodule

`default_nettype wire
